// File: sv/vgtl_pkg.sv
// Package with the shared types and constants of the vector grid trilinear lookup.
`timescale 1ns / 1ps

package vgtl_pkg;

    localparam int GRID_X_DEF   = 32;
    localparam int GRID_Y_DEF   = 32;
    localparam int GRID_Z_DEF   = 32;
    localparam int IDX_W        = 15;
    localparam int CELL_W       = 8;
    localparam int FRAC_W       = 16;
    localparam int FIELD_W      = 24;
    localparam int COORD_W      = 32;
    localparam int INV_W        = 24;
    localparam int QUEUE_DEPTH  = 4;
    localparam int PADDR_W      = 5;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [2:0] REG_ORIGIN_X   = 3'd0;
    localparam logic [2:0] REG_ORIGIN_Y   = 3'd1;
    localparam logic [2:0] REG_ORIGIN_Z   = 3'd2;
    localparam logic [2:0] REG_INV_STEP_X = 3'd3;
    localparam logic [2:0] REG_INV_STEP_Y = 3'd4;
    localparam logic [2:0] REG_INV_STEP_Z = 3'd5;

    localparam logic [INV_W-1:0] INV_STEP_RESET = 24'd65536;

    typedef struct packed {
        logic                        command;
        logic [IDX_W-1:0]            entry_index;
        logic signed [FIELD_W-1:0]   write_fx;
        logic signed [FIELD_W-1:0]   write_fy;
        logic signed [FIELD_W-1:0]   write_fz;
        logic signed [COORD_W-1:0]   coord_x;
        logic signed [COORD_W-1:0]   coord_y;
        logic signed [COORD_W-1:0]   coord_z;
    } t_in_item;

    typedef struct packed {
        logic signed [FIELD_W-1:0]   result_fx;
        logic signed [FIELD_W-1:0]   result_fy;
        logic signed [FIELD_W-1:0]   result_fz;
        logic                        inside_grid;
    } t_out_item;

    typedef struct packed {
        logic signed [COORD_W-1:0]   origin_x;
        logic signed [COORD_W-1:0]   origin_y;
        logic signed [COORD_W-1:0]   origin_z;
        logic [INV_W-1:0]            inv_step_x;
        logic [INV_W-1:0]            inv_step_y;
        logic [INV_W-1:0]            inv_step_z;
    } t_cfg;

    typedef struct packed {
        logic signed [FIELD_W-1:0]   fx;
        logic signed [FIELD_W-1:0]   fy;
        logic signed [FIELD_W-1:0]   fz;
    } t_vec;

    // One classified item as it waits between front and back.
    typedef struct packed {
        logic                        is_query;
        logic                        ok;
        logic [IDX_W-1:0]            idx;
        t_vec                        wdata;
        logic [CELL_W-1:0]           ix;
        logic [CELL_W-1:0]           iy;
        logic [CELL_W-1:0]           iz;
        logic [FRAC_W-1:0]           ux;
        logic [FRAC_W-1:0]           uy;
        logic [FRAC_W-1:0]           uz;
    } t_job;

endpackage

// File: sv/vector_grid_trilinear_lookup_top.sv
// Top level of the vector grid trilinear lookup: registers, front, queue and back.
`timescale 1ns / 1ps

//  channel   direction  handshake               payload
//  item      in         push / full             i_item   (t_in_item)
//  result    out        empty / pop             o_result (t_out_item)
//  config    in/out     psel, penable, pwrite   paddr, pwdata, prdata
//
//  A write beat and a query outside the grid are handled in the back part's idle state.
//  A query inside the grid takes eight corner reads from the single read port of the
//  field memory, then seven mixing steps through one shared interpolation unit, then
//  the hand-over to the result register.
//  Reset is synchronous and active low; the field memory is not cleared.
//  The front accepts beats into a four-entry queue while the back works or the
//  result register waits to be popped; full rises only when that queue is full.

module vector_grid_trilinear_lookup_top
    import vgtl_pkg::*;
#(
    parameter int GRID_X = GRID_X_DEF,
    parameter int GRID_Y = GRID_Y_DEF,
    parameter int GRID_Z = GRID_Z_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  t_in_item           i_item,
    output logic               empty,
    input  logic               pop,
    output t_out_item          o_result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    t_cfg       r_cfg;
    t_job       front_job, queue_job;
    logic       queue_valid, job_pop, out_valid, cfg_wr;
    logic [2:0] reg_sel;

    // Registers sit at byte address 4*i, so the word index is paddr[4:2].
    assign pready  = 1'b1;
    assign reg_sel = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.origin_x   <= '0;
            r_cfg.origin_y   <= '0;
            r_cfg.origin_z   <= '0;
            r_cfg.inv_step_x <= INV_STEP_RESET;
            r_cfg.inv_step_y <= INV_STEP_RESET;
            r_cfg.inv_step_z <= INV_STEP_RESET;
        end else if (cfg_wr) begin
            case (reg_sel)
                REG_ORIGIN_X:   r_cfg.origin_x   <= pwdata;
                REG_ORIGIN_Y:   r_cfg.origin_y   <= pwdata;
                REG_ORIGIN_Z:   r_cfg.origin_z   <= pwdata;
                REG_INV_STEP_X: r_cfg.inv_step_x <= pwdata[INV_W-1:0];
                REG_INV_STEP_Y: r_cfg.inv_step_y <= pwdata[INV_W-1:0];
                REG_INV_STEP_Z: r_cfg.inv_step_z <= pwdata[INV_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_ORIGIN_X:   prdata = r_cfg.origin_x;
            REG_ORIGIN_Y:   prdata = r_cfg.origin_y;
            REG_ORIGIN_Z:   prdata = r_cfg.origin_z;
            REG_INV_STEP_X: prdata = {8'd0, r_cfg.inv_step_x};
            REG_INV_STEP_Y: prdata = {8'd0, r_cfg.inv_step_y};
            REG_INV_STEP_Z: prdata = {8'd0, r_cfg.inv_step_z};
            default:        prdata = '0;
        endcase
    end

    // The front is pure arithmetic: each beat is classified on its way into the queue.
    vgtl_front #(
        .GRID_X(GRID_X),
        .GRID_Y(GRID_Y),
        .GRID_Z(GRID_Z)
    ) u_front (
        .i_item(i_item),
        .i_cfg (r_cfg),
        .o_job (front_job)
    );

    vgtl_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_data (front_job),
        .o_full (full),
        .i_pop  (job_pop),
        .o_valid(queue_valid),
        .o_data (queue_job)
    );

    vgtl_back #(
        .GRID_X(GRID_X),
        .GRID_Y(GRID_Y),
        .GRID_Z(GRID_Z)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job_valid(queue_valid),
        .i_job      (queue_job),
        .o_job_pop  (job_pop),
        .o_out_valid(out_valid),
        .o_out      (o_result),
        .i_out_pop  (pop)
    );

    assign empty = !out_valid;

`ifndef ASSERT_OFF
    // A rejected point always carries a zero field.
    a_zero_outside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_result.inside_grid) |->
        (o_result.result_fx == '0 && o_result.result_fy == '0 && o_result.result_fz == '0))
        else $error("rejected point carries a nonzero field");

    // The back never takes a job from an empty queue.
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        job_pop |-> queue_valid)
        else $error("back popped an empty queue");

    // After reset no result is waiting.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result present right after reset");
`endif

endmodule

// File: sv/vgtl_front.sv
// Front part: maps a query point to cell and fraction per axis and classifies items.
`timescale 1ns / 1ps

module vgtl_front
    import vgtl_pkg::*;
#(
    parameter int GRID_X = GRID_X_DEF,
    parameter int GRID_Y = GRID_Y_DEF,
    parameter int GRID_Z = GRID_Z_DEF
) (
    input  t_in_item i_item,
    input  t_cfg     i_cfg,
    output t_job     o_job
);

    typedef struct packed {
        logic              ok;
        logic [CELL_W-1:0] pos;
        logic [FRAC_W-1:0] frac;
    } t_axis;

    // Local coordinate is (coord - origin) * inv_step in Q.32.
    function automatic t_axis locate(
        input logic signed [COORD_W-1:0] c,
        input logic signed [COORD_W-1:0] o,
        input logic [INV_W-1:0]          inv,
        input int                        n
    );
        logic signed [COORD_W:0]         diff;
        logic signed [COORD_W+INV_W+1:0] p;
        t_axis                           a;
        diff   = $signed({c[COORD_W-1], c}) - $signed({o[COORD_W-1], o});
        p      = diff * $signed({1'b0, inv});
        a.ok   = !p[COORD_W+INV_W+1]
                 && (p[COORD_W+INV_W+1:32] < (COORD_W+INV_W-30)'(n - 1));
        a.pos  = p[32+CELL_W-1:32];
        a.frac = p[31:16];
        return a;
    endfunction

    t_axis ax, ay, az;

    always_comb begin
        ax = locate(i_item.coord_x, i_cfg.origin_x, i_cfg.inv_step_x, GRID_X);
        ay = locate(i_item.coord_y, i_cfg.origin_y, i_cfg.inv_step_y, GRID_Y);
        az = locate(i_item.coord_z, i_cfg.origin_z, i_cfg.inv_step_z, GRID_Z);
        o_job.is_query = (i_item.command == CMD_QUERY);
        o_job.ok       = ax.ok && ay.ok && az.ok;
        o_job.idx      = i_item.entry_index;
        o_job.wdata.fx = i_item.write_fx;
        o_job.wdata.fy = i_item.write_fy;
        o_job.wdata.fz = i_item.write_fz;
        o_job.ix       = ax.pos;
        o_job.iy       = ay.pos;
        o_job.iz       = az.pos;
        o_job.ux       = ax.frac;
        o_job.uy       = ay.frac;
        o_job.uz       = az.frac;
    end

endmodule

// File: sv/vgtl_queue.sv
// Short queue of classified items between the front and the back.
`timescale 1ns / 1ps

module vgtl_queue
    import vgtl_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_data,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_job o_data
);

    localparam int PW = $clog2(QUEUE_DEPTH);

    t_job          r_q [QUEUE_DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [PW:0]   r_cnt;
    logic          do_push, do_pop;

    assign o_full  = (r_cnt == (PW+1)'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_q[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wp <= r_wp + 1'b1;
            if (do_pop)  r_rp <= r_rp + 1'b1;
            if (do_push && !do_pop)      r_cnt <= r_cnt + 1'b1;
            else if (do_pop && !do_push) r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_q[r_wp] <= i_data;
    end

endmodule

// File: sv/vgtl_back.sv
// Back part: field memory, corner read sequencer, shared interpolation step, result register.
`timescale 1ns / 1ps

module vgtl_back
    import vgtl_pkg::*;
#(
    parameter int GRID_X = GRID_X_DEF,
    parameter int GRID_Y = GRID_Y_DEF,
    parameter int GRID_Z = GRID_Z_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_job_valid,
    input  t_job      i_job,
    output logic      o_job_pop,
    output logic      o_out_valid,
    output t_out_item o_out,
    input  logic      i_out_pop
);

    localparam int CELLS = GRID_X * GRID_Y * GRID_Z;
    localparam int DEPTH = (CELLS < (1 << IDX_W)) ? CELLS : (1 << IDX_W);
    localparam int AW    = $clog2(DEPTH);
    localparam int BW    = $clog2(CELLS);
    localparam int FY    = GRID_Z;
    localparam int FX    = GRID_Y * GRID_Z;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_READ = 4'b0010,
        ST_LERP = 4'b0100,
        ST_DONE = 4'b1000
    } t_state;

    // a + floor(((b - a) * u + 2^15) / 2^16), equal to the two-weight form.
    function automatic logic signed [FIELD_W-1:0] lerp1(
        input logic signed [FIELD_W-1:0] a,
        input logic signed [FIELD_W-1:0] b,
        input logic [FRAC_W-1:0]         u
    );
        logic signed [FIELD_W:0]          d;
        logic signed [FIELD_W+FRAC_W+1:0] m;
        logic signed [FIELD_W+2:0]        r;
        d = {b[FIELD_W-1], b} - {a[FIELD_W-1], a};
        m = d * $signed({1'b0, u}) + (FIELD_W+FRAC_W+2)'(32768);
        r = {{3{a[FIELD_W-1]}}, a} + {m[FIELD_W+FRAC_W+1], m[FIELD_W+FRAC_W+1:16]};
        return r[FIELD_W-1:0];
    endfunction

    function automatic t_vec lerp3(input t_vec a, input t_vec b, input logic [FRAC_W-1:0] u);
        t_vec r;
        r.fx = lerp1(a.fx, b.fx, u);
        r.fy = lerp1(a.fy, b.fy, u);
        r.fz = lerp1(a.fz, b.fz, u);
        return r;
    endfunction

    t_vec          r_mem [DEPTH];
    t_vec          r_rdata;
    t_state        r_state, n_state;
    t_job          r_job, n_job;
    logic [3:0]    r_cnt, n_cnt;
    logic [3:0]    r_len, n_len;
    t_vec          r_e [8];
    t_vec          n_e [8];
    logic          r_out_valid, n_out_valid;
    t_out_item     r_out, n_out;
    logic          out_free, rd_en, wr_en;
    logic [BW-1:0] addr_full;
    logic [2:0]    corner, wslot;
    logic [FRAC_W-1:0] u_sel;
    t_vec          step_res;

    assign out_free    = !r_out_valid || i_out_pop;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign corner      = r_cnt[2:0];
    assign rd_en       = (r_state == ST_READ) && !r_cnt[3];
    assign wr_en       = (r_state == ST_IDLE) && i_job_valid && !i_job.is_query
                         && (32'(i_job.idx) < 32'(CELLS));

    always_comb begin
        addr_full = BW'(r_job.ix) * BW'(FX) + BW'(r_job.iy) * BW'(FY) + BW'(r_job.iz)
                  + (corner[0] ? BW'(FX) : '0) + (corner[1] ? BW'(FY) : '0)
                  + BW'(corner[2]);
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[i_job.idx[AW-1:0]] <= i_job.wdata;
        if (rd_en) r_rdata <= r_mem[addr_full[AW-1:0]];
    end

    // The reduction runs as a queue: pairs leave the head, each mix joins the tail.
    always_comb begin
        if (r_len > 4'd4)      u_sel = r_job.ux;
        else if (r_len > 4'd2) u_sel = r_job.uy;
        else                   u_sel = r_job.uz;
        step_res = lerp3(r_e[0], r_e[1], u_sel);
        wslot    = 3'(r_len - 4'd2);
    end

    always_comb begin
        n_state     = r_state;
        n_job       = r_job;
        n_cnt       = r_cnt;
        n_len       = r_len;
        n_e         = r_e;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        o_job_pop   = 1'b0;
        if (i_out_pop) n_out_valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_job_valid) begin
                    if (!i_job.is_query) begin
                        o_job_pop = 1'b1;
                    end else if (!i_job.ok) begin
                        if (out_free) begin
                            o_job_pop   = 1'b1;
                            n_out_valid = 1'b1;
                            n_out       = '0;
                        end
                    end else begin
                        o_job_pop = 1'b1;
                        n_job     = i_job;
                        n_cnt     = '0;
                        n_state   = ST_READ;
                    end
                end
            end
            ST_READ: begin
                if (r_cnt != 4'd0) n_e[3'(r_cnt - 4'd1)] = r_rdata;
                n_cnt = r_cnt + 4'd1;
                if (r_cnt[3]) begin
                    n_len   = 4'd8;
                    n_state = ST_LERP;
                end
            end
            ST_LERP: begin
                for (int i = 0; i < 6; i++) n_e[i] = r_e[i+2];
                n_e[wslot] = step_res;
                n_len      = r_len - 4'd1;
                if (r_len == 4'd2) n_state = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    n_out_valid       = 1'b1;
                    n_out.result_fx   = r_e[0].fx;
                    n_out.result_fy   = r_e[0].fy;
                    n_out.result_fz   = r_e[0].fz;
                    n_out.inside_grid = 1'b1;
                    n_state           = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_job <= n_job;
        r_cnt <= n_cnt;
        r_len <= n_len;
        r_e   <= n_e;
        r_out <= n_out;
    end

endmodule
